@@ src/ars_pkg.sv @@
package ars_pkg;

    localparam int MAX_OPERATORS = 8;

    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 24;
    localparam int COUNT_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int CHOSEN_W = 3;
    localparam int TOTAL_W  = 19;
    localparam int AVG_W    = 25;
    localparam int RHO_W    = 9;
    localparam int REWARD_W = 8;

    localparam logic [RHO_W-1:0]   RHO_ONE   = 9'd256;
    localparam logic [AVG_W-1:0]   AVG_SAT   = 25'h100_0000;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 24'hFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [3:0]          RST_OPERATOR_COUNT  = 4'd5;
    localparam logic [REWARD_W-1:0] RST_REWARD_NEW_BEST = 8'd33;
    localparam logic [REWARD_W-1:0] RST_REWARD_BETTER   = 8'd20;
    localparam logic [REWARD_W-1:0] RST_REWARD_ACCEPTED = 8'd13;
    localparam logic [RHO_W-1:0]    RST_REACTION_RATE   = 9'd26;

    typedef enum logic [1:0] {
        ACT_SELECT,
        ACT_REWARD,
        ACT_SEGMENT,
        ACT_NONE
    } t_action;

    typedef enum logic [1:0] {
        OUTCOME_NONE,
        OUTCOME_ACCEPTED,
        OUTCOME_BETTER,
        OUTCOME_NEW_BEST
    } t_outcome;

    typedef enum logic [2:0] {
        CFG_OPERATOR_COUNT,
        CFG_REWARD_NEW_BEST,
        CFG_REWARD_BETTER,
        CFG_REWARD_ACCEPTED,
        CFG_REACTION_RATE
    } t_cfg_idx;

    typedef struct packed {
        logic [REWARD_W-1:0] reward_new_best;
        logic [REWARD_W-1:0] reward_better;
        logic [REWARD_W-1:0] reward_accepted;
        logic [RHO_W-1:0]    rho;
    } t_cfg;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_POINT,
        DP_CREDIT,
        DP_DIV_INIT,
        DP_BLEND,
        DP_WRITE,
        DP_CLEAR_NEXT,
        DP_RESTART,
        DP_SUM,
        DP_PRODUCT,
        DP_TARGET,
        DP_SCAN,
        DP_DONE
    } t_dp_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT,
        C_ACTION,
        C_MORE_ACTIVE,
        C_MORE_ALL,
        C_NO_USES,
        C_DIV_BUSY,
        C_NOT_SELECT
    } t_cond;

    typedef logic [4:0] t_pc;

    localparam t_pc S_IDLE       = 5'd0;
    localparam t_pc S_DISPATCH   = 5'd1;
    localparam t_pc S_GO_SELECT  = 5'd2;
    localparam t_pc S_GO_REWARD  = 5'd3;
    localparam t_pc S_GO_SEGMENT = 5'd4;
    localparam t_pc S_GO_NONE    = 5'd5;
    localparam t_pc S_CREDIT     = 5'd6;
    localparam t_pc S_DIV_INIT   = 5'd7;
    localparam t_pc S_DIV_WAIT   = 5'd8;
    localparam t_pc S_BLEND      = 5'd9;
    localparam t_pc S_WRITE      = 5'd10;
    localparam t_pc S_SEG_NEXT   = 5'd11;
    localparam t_pc S_SUM_INIT   = 5'd12;
    localparam t_pc S_SUM        = 5'd13;
    localparam t_pc S_SUM_EXIT   = 5'd14;
    localparam t_pc S_PRODUCT    = 5'd15;
    localparam t_pc S_TARGET     = 5'd16;
    localparam t_pc S_SCAN       = 5'd17;
    localparam t_pc S_DONE       = 5'd18;

    typedef struct packed {
        t_dp_op op;
        t_cond  cond;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        logic    more_active;
        logic    more_all;
        logic    no_uses;
        logic    div_busy;
        t_action action;
    } t_status;

    // The dispatch step adds the action code to its target, so the four
    // dispatch entries must stay consecutive and in action order.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{DP_NOP, C_JUMP, S_IDLE};
        case (pc)
            S_IDLE:       w = '{DP_LOAD,       C_WAIT,        S_IDLE};
            S_DISPATCH:   w = '{DP_NOP,        C_ACTION,      S_GO_SELECT};
            S_GO_SELECT:  w = '{DP_NOP,        C_JUMP,        S_SUM_INIT};
            S_GO_REWARD:  w = '{DP_POINT,      C_JUMP,        S_CREDIT};
            S_GO_SEGMENT: w = '{DP_NOP,        C_JUMP,        S_DIV_INIT};
            S_GO_NONE:    w = '{DP_NOP,        C_JUMP,        S_SUM_INIT};
            S_CREDIT:     w = '{DP_CREDIT,     C_JUMP,        S_SUM_INIT};
            S_DIV_INIT:   w = '{DP_DIV_INIT,   C_NO_USES,     S_SEG_NEXT};
            S_DIV_WAIT:   w = '{DP_NOP,        C_DIV_BUSY,    S_DIV_WAIT};
            S_BLEND:      w = '{DP_BLEND,      C_NEXT,        S_IDLE};
            S_WRITE:      w = '{DP_WRITE,      C_NEXT,        S_IDLE};
            S_SEG_NEXT:   w = '{DP_CLEAR_NEXT, C_MORE_ALL,    S_DIV_INIT};
            S_SUM_INIT:   w = '{DP_RESTART,    C_NEXT,        S_IDLE};
            S_SUM:        w = '{DP_SUM,        C_MORE_ACTIVE, S_SUM};
            S_SUM_EXIT:   w = '{DP_NOP,        C_NOT_SELECT,  S_DONE};
            S_PRODUCT:    w = '{DP_PRODUCT,    C_NEXT,        S_IDLE};
            S_TARGET:     w = '{DP_TARGET,     C_NEXT,        S_IDLE};
            S_SCAN:       w = '{DP_SCAN,       C_MORE_ACTIVE, S_SCAN};
            S_DONE:       w = '{DP_DONE,       C_JUMP,        S_IDLE};
            default:      w = '{DP_NOP,        C_JUMP,        S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/ars_div.sv @@
module ars_div #(
    parameter int DIVIDEND_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [15:0]           i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_count;
    logic [15:0]           r_rem;
    logic [15:0]           r_div;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_fit;
    logic [15:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_fit   = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = w_fit ? w_diff[15:0] : w_trial[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_start) begin
            r_count <= CNT_W'(DIVIDEND_W);
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_count != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
        end
    end

    assign o_busy     = (r_count != '0);
    assign o_quotient = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_div != '0) |-> (r_rem < r_div))
        else $error("Partial remainder has reached the divisor.");

endmodule

@@ src/ars_dp.sv @@
module ars_dp #(
    parameter int WEIGHT_FRAC_BITS = 8,
    localparam int IDX_W = $clog2(ars_pkg::MAX_OPERATORS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ars_pkg::t_dp_op                     i_op,
    input  ars_pkg::t_cfg                       i_cfg,
    input  logic [IDX_W-1:0]                    i_last,
    input  logic [1:0]                          i_action,
    input  logic [ars_pkg::FRAC_W-1:0]          i_random_fraction,
    input  logic [2:0]                          i_operator_index,
    input  logic [1:0]                          i_outcome,
    output ars_pkg::t_status                    o_status,
    output logic [ars_pkg::CHOSEN_W-1:0]        o_chosen_operator,
    output logic [ars_pkg::TOTAL_W-1:0]         o_total_weight
);

    localparam int ACC_W  = ars_pkg::WEIGHT_W + $clog2(ars_pkg::MAX_OPERATORS);
    localparam int PROD_W = ars_pkg::FRAC_W + ACC_W;
    localparam int DIVD_W = ars_pkg::SCORE_W + WEIGHT_FRAC_BITS;
    localparam logic [31:0] W_ONE_FULL = 32'd1 << WEIGHT_FRAC_BITS;
    localparam logic [ars_pkg::WEIGHT_W-1:0] W_RESET = W_ONE_FULL[ars_pkg::WEIGHT_W-1:0];

    logic [ars_pkg::WEIGHT_W-1:0] r_weight [ars_pkg::MAX_OPERATORS];
    logic [ars_pkg::SCORE_W-1:0]  r_score  [ars_pkg::MAX_OPERATORS];
    logic [ars_pkg::COUNT_W-1:0]  r_count  [ars_pkg::MAX_OPERATORS];

    logic [IDX_W-1:0]  r_op;
    logic [ACC_W-1:0]  r_acc;
    logic [IDX_W-1:0]  r_chosen;
    logic              r_found;
    logic              r_hit;

    ars_pkg::t_action  r_action;
    ars_pkg::t_outcome r_outcome;
    logic [ars_pkg::FRAC_W-1:0] r_frac;
    logic [2:0]        r_idx;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_target;
    logic [24:0]       r_pa;
    logic [33:0]       r_pb;

    logic [ars_pkg::WEIGHT_W-1:0] w_sel_weight;
    logic [ars_pkg::SCORE_W-1:0]  w_sel_score;
    logic [ars_pkg::COUNT_W-1:0]  w_sel_count;
    logic [ACC_W-1:0]             w_run;
    logic [ACC_W-1:0]             n_target;
    logic [7:0]                   w_idx_wide;
    logic [ars_pkg::REWARD_W-1:0] w_reward;
    logic [ars_pkg::SCORE_W:0]    w_score_sum;
    logic [ars_pkg::SCORE_W-1:0]  n_score;
    logic [ars_pkg::COUNT_W-1:0]  n_count;
    logic                         w_div_start;
    logic                         w_div_busy;
    logic [DIVD_W-1:0]            w_dividend;
    logic [DIVD_W-1:0]            w_quotient;
    logic [ars_pkg::AVG_W-1:0]    w_avg;
    logic [ars_pkg::RHO_W-1:0]    w_rho_inv;
    logic [34:0]                  w_blend_sum;
    logic [26:0]                  w_blend_shift;
    logic [ars_pkg::WEIGHT_W-1:0] n_weight;
    logic [31:0]                  w_total_wide;
    logic [7:0]                   w_chosen_wide;

    assign w_sel_weight = r_weight[r_op];
    assign w_sel_score  = r_score[r_op];
    assign w_sel_count  = r_count[r_op];

    always_comb begin
        w_run      = r_acc + ACC_W'(w_sel_weight);
        n_target   = r_prod[PROD_W-1:ars_pkg::FRAC_W] + 1'b1;
        w_idx_wide = 8'(r_idx);
        case (r_outcome)
            ars_pkg::OUTCOME_NEW_BEST: w_reward = i_cfg.reward_new_best;
            ars_pkg::OUTCOME_BETTER:   w_reward = i_cfg.reward_better;
            ars_pkg::OUTCOME_ACCEPTED: w_reward = i_cfg.reward_accepted;
            default:                   w_reward = '0;
        endcase
        w_score_sum = {1'b0, w_sel_score} + (ars_pkg::SCORE_W + 1)'(w_reward);
        n_score     = w_score_sum[ars_pkg::SCORE_W] ? ars_pkg::SCORE_MAX
                                                     : w_score_sum[ars_pkg::SCORE_W-1:0];
        n_count     = (w_sel_count == ars_pkg::COUNT_MAX) ? w_sel_count
                                                           : w_sel_count + 1'b1;
    end

    // Averages of 2^24 and above saturate the blended weight whenever rho is
    // non-zero, so the quotient is clamped there to keep the multiplier narrow.
    always_comb begin
        w_div_start   = (i_op == ars_pkg::DP_DIV_INIT);
        w_dividend    = {w_sel_score, {WEIGHT_FRAC_BITS{1'b0}}};
        w_avg         = (|w_quotient[DIVD_W-1:ars_pkg::SCORE_W]) ? ars_pkg::AVG_SAT
                        : {1'b0, w_quotient[ars_pkg::SCORE_W-1:0]};
        w_rho_inv     = ars_pkg::RHO_ONE - i_cfg.rho;
        w_blend_sum   = 35'(r_pa) + 35'(r_pb) + 35'd128;
        w_blend_shift = w_blend_sum[34:8];
        n_weight      = (|w_blend_shift[26:16]) ? 16'hFFFF : w_blend_shift[15:0];
    end

    ars_div #(
        .DIVIDEND_W (DIVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_sel_count),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ars_pkg::MAX_OPERATORS; i++) begin
                r_weight[i] <= W_RESET;
                r_score[i]  <= '0;
                r_count[i]  <= '0;
            end
            r_op     <= '0;
            r_acc    <= '0;
            r_chosen <= '0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            case (i_op)
                ars_pkg::DP_LOAD: begin
                    r_op     <= '0;
                    r_acc    <= '0;
                    r_chosen <= '0;
                    r_found  <= 1'b0;
                end
                ars_pkg::DP_POINT: begin
                    r_op  <= w_idx_wide[IDX_W-1:0];
                    r_hit <= (w_idx_wide <= 8'(i_last));
                end
                ars_pkg::DP_CREDIT: begin
                    if (r_hit) begin
                        r_score[r_op] <= n_score;
                        r_count[r_op] <= n_count;
                    end
                end
                ars_pkg::DP_WRITE: begin
                    r_weight[r_op] <= n_weight;
                end
                ars_pkg::DP_CLEAR_NEXT: begin
                    r_score[r_op] <= '0;
                    r_count[r_op] <= '0;
                    r_op          <= r_op + 1'b1;
                end
                ars_pkg::DP_RESTART: begin
                    r_op  <= '0;
                    r_acc <= '0;
                end
                ars_pkg::DP_SUM: begin
                    r_acc <= w_run;
                    r_op  <= r_op + 1'b1;
                end
                ars_pkg::DP_TARGET: begin
                    r_acc <= '0;
                    r_op  <= '0;
                end
                ars_pkg::DP_SCAN: begin
                    r_acc <= w_run;
                    r_op  <= r_op + 1'b1;
                    if (!r_found && (w_run >= r_target)) begin
                        r_chosen <= r_op;
                        r_found  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            ars_pkg::DP_LOAD: begin
                r_action  <= ars_pkg::t_action'(i_action);
                r_outcome <= ars_pkg::t_outcome'(i_outcome);
                r_frac    <= i_random_fraction;
                r_idx     <= i_operator_index;
            end
            ars_pkg::DP_PRODUCT: begin
                r_prod <= PROD_W'(r_frac) * PROD_W'(r_acc);
            end
            ars_pkg::DP_TARGET: begin
                r_target <= n_target;
            end
            ars_pkg::DP_BLEND: begin
                r_pa <= 25'(w_rho_inv) * 25'(r_weight[r_op]);
                r_pb <= 34'(i_cfg.rho) * 34'(w_avg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.more_active = (r_op != i_last);
        o_status.more_all    = (r_op != IDX_W'(ars_pkg::MAX_OPERATORS - 1));
        o_status.no_uses     = (w_sel_count == '0);
        o_status.div_busy    = w_div_busy;
        o_status.action      = r_action;
        w_total_wide         = 32'(r_acc);
        w_chosen_wide        = 8'(r_chosen);
        o_total_weight       = w_total_wide[ars_pkg::TOTAL_W-1:0];
        o_chosen_operator    = w_chosen_wide[ars_pkg::CHOSEN_W-1:0];
    end

    a_select_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == ars_pkg::DP_DONE && r_action == ars_pkg::ACT_SELECT && r_acc != '0)
        |-> r_found)
        else $error("Selection ended without reaching the target.");

    a_chosen_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == ars_pkg::DP_DONE && r_action == ars_pkg::ACT_SELECT)
        |-> (r_chosen <= i_last))
        else $error("Chosen operator lies outside the active set.");

endmodule

@@ src/ars_seq.sv @@
module ars_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ars_pkg::t_status i_status,
    output ars_pkg::t_dp_op  o_op,
    output logic             o_busy
);

    ars_pkg::t_pc    r_pc;
    ars_pkg::t_pc    n_pc;
    ars_pkg::t_uword w_word;

    assign w_word = ars_pkg::ucode(r_pc);

    always_comb begin
        case (w_word.cond)
            ars_pkg::C_NEXT:        n_pc = r_pc + 1'b1;
            ars_pkg::C_JUMP:        n_pc = w_word.target;
            ars_pkg::C_WAIT:        n_pc = i_start ? r_pc + 1'b1 : w_word.target;
            ars_pkg::C_ACTION:      n_pc = w_word.target + ars_pkg::t_pc'(i_status.action);
            ars_pkg::C_MORE_ACTIVE: n_pc = i_status.more_active ? w_word.target : r_pc + 1'b1;
            ars_pkg::C_MORE_ALL:    n_pc = i_status.more_all ? w_word.target : r_pc + 1'b1;
            ars_pkg::C_NO_USES:     n_pc = i_status.no_uses ? w_word.target : r_pc + 1'b1;
            ars_pkg::C_DIV_BUSY:    n_pc = i_status.div_busy ? w_word.target : r_pc + 1'b1;
            ars_pkg::C_NOT_SELECT:  n_pc = (i_status.action != ars_pkg::ACT_SELECT)
                                           ? w_word.target : r_pc + 1'b1;
            default:                n_pc = ars_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = w_word.op;
        o_busy = (r_pc != ars_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ars_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= ars_pkg::S_DONE)
        else $error("Step counter has left the microprogram.");

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ars_pkg::S_DONE) |=> (r_pc == ars_pkg::S_IDLE))
        else $error("Result step did not return to idle.");

endmodule

@@ src/adaptive_roulette_selector.sv @@
// Channel   Dir  Ports                                              Transfer
// request   in   start, i_action, i_random_fraction,                start & !busy
//                i_operator_index, i_outcome
// result    out  o_valid, o_chosen_operator, o_total_weight         o_valid, one cycle
// config    in   i_cfg_we, i_cfg_idx, i_cfg_data                    i_cfg_we
//
// For every action, the microprogram sums the weights of the active operators before the
// result strobe; a select request then scans them against the scaled random fraction, a
// reward first credits the named operator, and a segment end first visits all eight table
// entries, dividing and blending the weight of each used one and clearing every entry.
// The microprogram visits the weight table one entry per step, and the divider produces
// one quotient bit per cycle.
// Reset is synchronous and loads every table at once; there is no clearing pass.
// busy stays high up to and including the strobe cycle; the receiver cannot stall.
module adaptive_roulette_selector #(
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_random_fraction,
    input  logic [2:0]  i_operator_index,
    input  logic [1:0]  i_outcome,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_chosen_operator,
    output logic [18:0] o_total_weight
);

    localparam int IDX_W = $clog2(ars_pkg::MAX_OPERATORS);

    logic [3:0] r_operator_count;
    logic [7:0] r_reward_new_best;
    logic [7:0] r_reward_better;
    logic [7:0] r_reward_accepted;
    logic [8:0] r_reaction_rate;

    ars_pkg::t_cfg    w_cfg;
    ars_pkg::t_status w_status;
    ars_pkg::t_dp_op  w_op;
    logic [4:0]       w_cnt;
    logic [4:0]       w_max;
    logic [4:0]       w_last_wide;
    logic [IDX_W-1:0] w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operator_count  <= ars_pkg::RST_OPERATOR_COUNT;
            r_reward_new_best <= ars_pkg::RST_REWARD_NEW_BEST;
            r_reward_better   <= ars_pkg::RST_REWARD_BETTER;
            r_reward_accepted <= ars_pkg::RST_REWARD_ACCEPTED;
            r_reaction_rate   <= ars_pkg::RST_REACTION_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ars_pkg::CFG_OPERATOR_COUNT:  r_operator_count  <= i_cfg_data[3:0];
                ars_pkg::CFG_REWARD_NEW_BEST: r_reward_new_best <= i_cfg_data[7:0];
                ars_pkg::CFG_REWARD_BETTER:   r_reward_better   <= i_cfg_data[7:0];
                ars_pkg::CFG_REWARD_ACCEPTED: r_reward_accepted <= i_cfg_data[7:0];
                ars_pkg::CFG_REACTION_RATE:   r_reaction_rate   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A count of zero behaves as one and counts beyond the table as the full table.
    always_comb begin
        w_cnt = {1'b0, r_operator_count};
        w_max = 5'(ars_pkg::MAX_OPERATORS);
        if (w_cnt == 5'd0) begin
            w_last_wide = 5'd0;
        end else if (w_cnt > w_max) begin
            w_last_wide = w_max - 5'd1;
        end else begin
            w_last_wide = w_cnt - 5'd1;
        end
        w_last = w_last_wide[IDX_W-1:0];

        w_cfg.reward_new_best = r_reward_new_best;
        w_cfg.reward_better   = r_reward_better;
        w_cfg.reward_accepted = r_reward_accepted;
        w_cfg.rho             = (r_reaction_rate > ars_pkg::RHO_ONE) ? ars_pkg::RHO_ONE
                                                                      : r_reaction_rate;
    end

    ars_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy)
    );

    ars_dp #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (w_op),
        .i_cfg             (w_cfg),
        .i_last            (w_last),
        .i_action          (i_action),
        .i_random_fraction (i_random_fraction),
        .i_operator_index  (i_operator_index),
        .i_outcome         (i_outcome),
        .o_status          (w_status),
        .o_chosen_operator (o_chosen_operator),
        .o_total_weight    (o_total_weight)
    );

    assign o_valid = (w_op == ars_pkg::DP_DONE);

endmodule
